/* hw/rtl/anbx_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the Annex B NAL splitter.
// Used by the front, queue, back end and top level; no dependencies.
package anbx_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSTART = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MD_HEAD,
		MD_UNIT,
		MD_SKIP
	} mode_t;

	typedef enum logic [2:0] {
		GP_ZEROS1,
		GP_BITS1,
		GP_ZEROS2,
		GP_BITS2,
		GP_DONE,
		GP_BAD
	} gp_t;

	localparam logic [3:0]  KIND_NONE = 4'hf;
	localparam logic [2:0]  PFX_NONE  = 3'd0;
	localparam logic [2:0]  PFX3      = 3'd3;
	localparam logic [2:0]  PFX4      = 3'd4;
	localparam logic [23:0] START3    = 24'h000001;
	localparam logic [31:0] START4    = 32'h00000001;

	localparam logic [2:0] FC_NONE = 3'd0;
	localparam logic [2:0] FC_P    = 3'd1;
	localparam logic [2:0] FC_B    = 3'd2;
	localparam logic [2:0] FC_I    = 3'd3;
	localparam logic [2:0] FC_SEI  = 3'd4;
	localparam logic [2:0] FC_SPS  = 3'd5;
	localparam logic [2:0] FC_PPS  = 3'd6;

	typedef struct packed {
		gp_t         phase;
		logic [5:0]  zero_run;
		logic [31:0] value;
		logic [3:0]  kind;
	} gs_t;

	localparam gs_t GS_RESET = '{phase: GP_ZEROS1, zero_run: 6'd0, value: 32'd0,
		kind: KIND_NONE};

	// Queue word: up to four payload bytes, oldest in word[31:24], and an optional close.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
		status_t     status;
		logic [2:0]  prefix;
		logic        done;
	} anbx_entry_t;

endpackage

/* hw/rtl/annexb_nal_splitter_classifier.sv */
`timescale 1ns / 1ps
// Top level of the Annex B NAL splitter and classifier.
// Depends on anbx_pkg, anbx_front, anbx_fifo and anbx_back.
//
// Input channel: one stream byte per word (data_byte, end_of_stream), in_valid
// and in_stall. Output channel: one word per NAL unit or stream error, out_valid
// and out_stall, held in an output register.
// Throughput: one byte per cycle. Bytes that close a stream release up to four
// held payload bytes at once; the back end takes these at one byte per cycle,
// so the four-word queue absorbs that word while the back end works through it.
// Path: the word that closes a unit is written into the queue, and the back end
// registers its result in the output register once it has taken every payload byte.
// in_stall rises only when the queue is full; a stalled result holds in the
// output register while the back end keeps decoding up to the next close.
// Reset clears all control state; the block then waits for a start code at the
// head of a new stream.
module annexb_nal_splitter_classifier #(
	parameter int MAX_NAL_BYTES = 262144
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            data_byte,
	input  logic                                  end_of_stream,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic [2:0]                            prefix_length,
	output logic [$clog2(MAX_NAL_BYTES + 1)-1:0]  nal_length,
	output logic                                  length_overflow,
	output logic                                  forbidden_zero,
	output logic [1:0]                            reference_idc,
	output logic [4:0]                            unit_type,
	output logic [2:0]                            frame_class,
	output logic                                  stream_done
);
	import anbx_pkg::*;

	localparam int LW = $clog2(MAX_NAL_BYTES + 1);

	anbx_entry_t push_entry, head;
	logic        push, full, pop, empty;

	anbx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.full          (full),
		.push          (push),
		.push_entry    (push_entry)
	);

	anbx_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	anbx_back #(
		.MAX_NAL_BYTES (MAX_NAL_BYTES),
		.LW            (LW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.have            (!empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.prefix_length   (prefix_length),
		.nal_length      (nal_length),
		.length_overflow (length_overflow),
		.forbidden_zero  (forbidden_zero),
		.reference_idc   (reference_idc),
		.unit_type       (unit_type),
		.frame_class     (frame_class),
		.stream_done     (stream_done)
	);

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(prefix_length == PFX_NONE) && (nal_length == '0) && (frame_class == FC_NONE))
		else $error("error result carries unit fields");

	a_empty_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) && (nal_length == '0) |->
			!forbidden_zero && (reference_idc == 2'd0) && (unit_type == 5'd0))
		else $error("empty unit carries header fields");

	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_overflow |-> (nal_length == LW'(MAX_NAL_BYTES)))
		else $error("overflowed length not saturated");

	a_short_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SHORT) |-> stream_done)
		else $error("short stream result does not close the stream");

	a_ok_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> (prefix_length == PFX3) || (prefix_length == PFX4))
		else $error("unit result without a valid start code length");

endmodule

/* hw/rtl/anbx_front.sv */
`timescale 1ns / 1ps
// Front end: start code search and payload release for the NAL splitter.
// Depends on anbx_pkg; pushes words into anbx_fifo.
module anbx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_stream,
	input  logic                  full,
	output logic                  push,
	output anbx_pkg::anbx_entry_t push_entry
);
	import anbx_pkg::*;

	mode_t       mode_q, mode_d;
	logic [31:0] win_q, win_d;
	logic [2:0]  hc_q, hc_d;
	logic [2:0]  prefix_q, prefix_d;

	logic [31:0] win_sh;
	logic [2:0]  hc_inc;
	logic        is_s3, is_s4, head_hit, head_full, accept, gen;
	logic [2:0]  head_pfx;
	logic [31:0] aligned;
	anbx_entry_t ent;

	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign win_sh    = {win_q[23:0], data_byte};
	assign hc_inc    = hc_q + 3'd1;
	assign is_s4     = (win_sh == START4);
	assign is_s3     = (win_sh[23:0] == START3);
	assign head_full = (hc_inc >= 3'd4);
	assign head_hit  = ((hc_inc == 3'd3) && is_s3) || ((hc_inc == 3'd4) && is_s4);
	assign head_pfx  = (hc_inc == 3'd3) ? PFX3 : PFX4;

	always_comb begin
		case (hc_inc)
			3'd1: aligned = {win_sh[7:0], 24'h000000};
			3'd2: aligned = {win_sh[15:0], 16'h0000};
			3'd3: aligned = {win_sh[23:0], 8'h00};
			default: aligned = win_sh;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		win_d    = win_sh;
		hc_d     = hc_inc;
		prefix_d = prefix_q;
		case (mode_q)
			MD_HEAD: begin
				if (head_hit && !end_of_stream) begin
					mode_d   = MD_UNIT;
					win_d    = START4;
					hc_d     = 3'd0;
					prefix_d = head_pfx;
				end else if (head_hit || head_full || end_of_stream) begin
					mode_d   = (head_full && !head_hit && !end_of_stream) ? MD_SKIP : MD_HEAD;
					win_d    = 32'd0;
					hc_d     = 3'd0;
					prefix_d = PFX_NONE;
				end
			end
			MD_UNIT: begin
				if (end_of_stream) begin
					mode_d   = MD_HEAD;
					win_d    = 32'd0;
					hc_d     = 3'd0;
					prefix_d = PFX_NONE;
				end else if (is_s4 || is_s3) begin
					win_d    = START4;
					hc_d     = 3'd0;
					prefix_d = is_s4 ? PFX4 : PFX3;
				end else if (head_full) begin
					hc_d = 3'd3;
				end
			end
			MD_SKIP: begin
				win_d  = win_q;
				hc_d   = hc_q;
				mode_d = end_of_stream ? MD_HEAD : MD_SKIP;
			end
			default: begin
				mode_d   = MD_HEAD;
				win_d    = 32'd0;
				hc_d     = 3'd0;
				prefix_d = PFX_NONE;
			end
		endcase
	end

	always_comb begin
		gen         = 1'b0;
		ent.word    = win_sh;
		ent.count   = 3'd0;
		ent.last    = 1'b1;
		ent.status  = ST_OK;
		ent.prefix  = prefix_q;
		ent.done    = end_of_stream;
		case (mode_q)
			MD_HEAD: begin
				if (head_hit) begin
					gen        = end_of_stream;
					ent.prefix = head_pfx;
				end else if (head_full) begin
					gen        = 1'b1;
					ent.status = ST_NOSTART;
					ent.prefix = PFX_NONE;
				end else if (end_of_stream) begin
					gen        = 1'b1;
					ent.status = ST_SHORT;
					ent.prefix = PFX_NONE;
				end
			end
			MD_UNIT: begin
				if (is_s4) begin
					gen = 1'b1;
				end else if (is_s3) begin
					gen       = 1'b1;
					ent.count = head_full ? 3'd1 : 3'd0;
				end else if (end_of_stream) begin
					gen       = 1'b1;
					ent.count = hc_inc;
					ent.word  = aligned;
				end else if (head_full) begin
					gen       = 1'b1;
					ent.count = 3'd1;
					ent.last  = 1'b0;
				end
			end
			default: gen = 1'b0;
		endcase
	end

	assign push       = accept && gen;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MD_HEAD;
			win_q    <= 32'd0;
			hc_q     <= 3'd0;
			prefix_q <= PFX_NONE;
		end else if (accept) begin
			mode_q   <= mode_d;
			win_q    <= win_d;
			hc_q     <= hc_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

/* hw/rtl/anbx_fifo.sv */
`timescale 1ns / 1ps
// Four-word queue between the front and back ends of the NAL splitter.
// Depends on anbx_pkg for the word layout.
module anbx_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  anbx_pkg::anbx_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output anbx_pkg::anbx_entry_t head
);
	import anbx_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	anbx_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == NW'(0));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + NW'(1);
				2'b01: cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/anbx_back.sv */
`timescale 1ns / 1ps
// Back end: payload count, header capture, exp-Golomb decode and result register.
// Depends on anbx_pkg; drains anbx_fifo one payload byte per cycle unless a result waits on out_stall.
module anbx_back #(
	parameter int MAX_NAL_BYTES = 262144,
	parameter int LW            = 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  have,
	input  anbx_pkg::anbx_entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [2:0]            prefix_length,
	output logic [LW-1:0]         nal_length,
	output logic                  length_overflow,
	output logic                  forbidden_zero,
	output logic [1:0]            reference_idc,
	output logic [4:0]            unit_type,
	output logic [2:0]            frame_class,
	output logic                  stream_done
);
	import anbx_pkg::*;

	localparam int CW = $clog2(MAX_NAL_BYTES + 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_NAL_BYTES);

	localparam logic [4:0] UT_SLICE = 5'd1;
	localparam logic [4:0] UT_IDR   = 5'd5;
	localparam logic [4:0] UT_SEI   = 5'd6;
	localparam logic [4:0] UT_SPS   = 5'd7;
	localparam logic [4:0] UT_PPS   = 5'd8;

	localparam logic [3:0] SLT_P      = 4'd0;
	localparam logic [3:0] SLT_B      = 4'd1;
	localparam logic [3:0] SLT_I      = 4'd2;
	localparam logic [3:0] SLT_SP     = 4'd3;
	localparam logic [3:0] SLT_SI     = 4'd4;
	localparam logic [3:0] SLT_P_ALL  = 4'd5;
	localparam logic [3:0] SLT_B_ALL  = 4'd6;
	localparam logic [3:0] SLT_I_ALL  = 4'd7;
	localparam logic [3:0] SLT_SP_ALL = 4'd8;
	localparam logic [3:0] SLT_SI_ALL = 4'd9;
	localparam logic [31:0] SLT_LIMIT = 32'd10;

	function automatic gs_t end_value(gs_t s);
		gs_t r;
		r = s;
		if (r.phase == GP_BITS1) begin
			r.phase    = GP_ZEROS2;
			r.zero_run = 6'd0;
		end else begin
			r.kind  = (r.value < SLT_LIMIT) ? r.value[3:0] : KIND_NONE;
			r.phase = GP_DONE;
		end
		return r;
	endfunction

	function automatic gs_t golomb_step(gs_t s, logic b_in);
		gs_t r;
		r = s;
		case (r.phase)
			GP_ZEROS1, GP_ZEROS2: begin
				if (!b_in) begin
					r.zero_run = r.zero_run + 6'd1;
					if (r.zero_run >= 6'd32) begin
						r.phase = GP_BAD;
					end
				end else begin
					r.phase = (r.phase == GP_ZEROS1) ? GP_BITS1 : GP_BITS2;
					r.value = 32'd1;
					if (r.zero_run == 6'd0) begin
						r.value = 32'd0;
						r       = end_value(r);
					end
				end
			end
			GP_BITS1, GP_BITS2: begin
				r.value    = {r.value[30:0], b_in};
				r.zero_run = r.zero_run - 6'd1;
				if (r.zero_run == 6'd0) begin
					r.value = r.value - 32'd1;
					r       = end_value(r);
				end
			end
			default: r = s;
		endcase
		return r;
	endfunction

	function automatic gs_t golomb_byte(gs_t s, logic [7:0] b_in);
		gs_t r;
		r = s;
		for (int i = 7; i >= 0; i--) begin
			r = golomb_step(r, b_in[i]);
		end
		return r;
	endfunction

	function automatic logic [2:0] slice_class(logic [3:0] k);
		logic [2:0] c;
		if (k inside {SLT_P, SLT_SP, SLT_P_ALL, SLT_SP_ALL}) begin
			c = FC_P;
		end else if (k inside {SLT_B, SLT_B_ALL}) begin
			c = FC_B;
		end else if (k inside {SLT_I, SLT_SI, SLT_I_ALL, SLT_SI_ALL}) begin
			c = FC_I;
		end else begin
			c = FC_NONE;
		end
		return c;
	endfunction

	logic [1:0]    pos_q;
	logic [CW-1:0] cnt_q, cnt_nx;
	logic [7:0]    hdr_q, hdr_nx;
	gs_t           gs_q, gs_nx;

	logic          out_valid_q;
	status_t       status_q;
	logic [2:0]    prefix_q, class_q;
	logic [LW-1:0] len_q;
	logic          ovf_q, fz_q, done_q;
	logic [1:0]    idc_q;
	logic [4:0]    type_q;

	logic [7:0]    cur_byte, hdr_e;
	logic          take_now, finishing, emit, step;
	logic [2:0]    class_e;
	logic [LW-1:0] len_e;
	logic          ovf_e;

	always_comb begin
		case (pos_q)
			2'd0: cur_byte = head.word[31:24];
			2'd1: cur_byte = head.word[23:16];
			2'd2: cur_byte = head.word[15:8];
			default: cur_byte = head.word[7:0];
		endcase
	end

	assign take_now  = (head.count != 3'd0);
	assign finishing = !take_now || ({1'b0, pos_q} == (head.count - 3'd1));
	assign emit      = have && finishing && head.last;
	assign step      = have && !(emit && out_valid_q && out_stall);
	assign pop       = step && finishing;

	always_comb begin
		cnt_nx = cnt_q;
		hdr_nx = hdr_q;
		gs_nx  = gs_q;
		if (take_now) begin
			if (cnt_q == CW'(0)) begin
				hdr_nx = cur_byte;
			end else begin
				gs_nx = golomb_byte(gs_q, cur_byte);
			end
			if (cnt_q <= MAX_C) begin
				cnt_nx = cnt_q + CW'(1);
			end
		end
	end

	assign hdr_e = (cnt_nx != CW'(0)) ? hdr_nx : 8'h00;
	assign ovf_e = (cnt_nx > MAX_C);
	assign len_e = ovf_e ? LW'(MAX_NAL_BYTES) : cnt_nx[LW-1:0];

	always_comb begin
		if (hdr_e[4:0] inside {UT_SLICE, UT_IDR}) begin
			class_e = slice_class(gs_nx.kind);
		end else if (hdr_e[4:0] == UT_SEI) begin
			class_e = FC_SEI;
		end else if (hdr_e[4:0] == UT_SPS) begin
			class_e = FC_SPS;
		end else if (hdr_e[4:0] == UT_PPS) begin
			class_e = FC_PPS;
		end else begin
			class_e = FC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			cnt_q       <= '0;
			hdr_q       <= 8'h00;
			gs_q        <= GS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				pos_q <= finishing ? 2'd0 : pos_q + 2'd1;
				if (finishing && head.last) begin
					cnt_q <= '0;
					hdr_q <= 8'h00;
					gs_q  <= GS_RESET;
				end else begin
					cnt_q <= cnt_nx;
					hdr_q <= hdr_nx;
					gs_q  <= gs_nx;
				end
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_q <= head.status;
			prefix_q <= head.prefix;
			len_q    <= len_e;
			ovf_q    <= ovf_e;
			fz_q     <= hdr_e[7];
			idc_q    <= hdr_e[6:5];
			type_q   <= hdr_e[4:0];
			class_q  <= class_e;
			done_q   <= head.done;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign prefix_length   = prefix_q;
	assign nal_length      = len_q;
	assign length_overflow = ovf_q;
	assign forbidden_zero  = fz_q;
	assign reference_idc   = idc_q;
	assign unit_type       = type_q;
	assign frame_class     = class_q;
	assign stream_done     = done_q;

endmodule

/* verif/tb_annexb_nal_splitter_classifier.sv */
`timescale 1ns / 1ps
// Self-checking testbench for annexb_nal_splitter_classifier: random and directed Annex B
// byte streams, a scoreboard class that predicts each NAL result, random idling on both sides.
// Depends on anbx_pkg and the top level of the block.
module tb_annexb_nal_splitter_classifier;
	import anbx_pkg::*;

	localparam int NAL_MAX = 262144;
	localparam int LEN_W   = $clog2(NAL_MAX + 1);
	localparam int LIMIT   = 1000000;

	localparam logic [4:0] NUT_SLICE = 5'd1;
	localparam logic [4:0] NUT_IDR   = 5'd5;
	localparam logic [4:0] NUT_SEI   = 5'd6;
	localparam logic [4:0] NUT_SPS   = 5'd7;
	localparam logic [4:0] NUT_PPS   = 5'd8;

	localparam logic [3:0] SL_P     = 4'd0;
	localparam logic [3:0] SL_B     = 4'd1;
	localparam logic [3:0] SL_I     = 4'd2;
	localparam logic [3:0] SL_SP    = 4'd3;
	localparam logic [3:0] SL_SI    = 4'd4;
	localparam logic [3:0] SL_WRAP  = 4'd5;
	localparam int         SL_COUNT = 10;

	typedef struct packed {
		status_t          status;
		logic [2:0]       prefix;
		logic [LEN_W-1:0] length;
		logic             ovf;
		logic             fz;
		logic [1:0]       idc;
		logic [4:0]       utype;
		logic [2:0]       fclass;
		logic             done;
	} nal_rec_t;

	class nal_scoreboard;
		nal_rec_t    expected_nals[$];
		int          errors;
		int          n_results;
		int          n_faults;
		int          n_saturated;
		mode_t       mode;
		logic [31:0] window;
		int unsigned pend;
		logic [2:0]  pfx;
		int unsigned count;
		logic [7:0]  hdr;
		gp_t         phase;
		int unsigned zeros;
		logic [31:0] gval;
		logic [3:0]  kind;

		function new();
			errors = 0;
			n_results = 0;
			n_faults = 0;
			n_saturated = 0;
			clear_stream();
		endfunction

		function void reset_golomb();
			phase = GP_ZEROS1;
			zeros = 0;
			gval = '0;
			kind = KIND_NONE;
		endfunction

		function void clear_stream();
			mode = MD_HEAD;
			window = '0;
			pend = 0;
			pfx = PFX_NONE;
			count = 0;
			hdr = '0;
			reset_golomb();
		endfunction

		function void open_unit(logic [2:0] p);
			pfx = p;
			window = START4;
			pend = 0;
			count = 0;
			hdr = '0;
			reset_golomb();
		endfunction

		function void close_value();
			if (phase == GP_BITS1) begin
				phase = GP_ZEROS2;
				zeros = 0;
			end else begin
				kind = (gval < SL_COUNT) ? gval[3:0] : KIND_NONE;
				phase = GP_DONE;
			end
		endfunction

		function void golomb_step(logic b);
			case (phase)
				GP_ZEROS1, GP_ZEROS2: begin
					if (!b) begin
						zeros++;
						if (zeros >= 32) phase = GP_BAD;
					end else begin
						if (phase == GP_ZEROS1) phase = GP_BITS1;
						else phase = GP_BITS2;
						gval = 32'd1;
						if (zeros == 0) begin
							gval = '0;
							close_value();
						end
					end
				end
				GP_BITS1, GP_BITS2: begin
					gval = {gval[30:0], b};
					zeros--;
					if (zeros == 0) begin
						gval = gval - 32'd1;
						close_value();
					end
				end
				default: ;
			endcase
		endfunction

		function void absorb(logic [7:0] b);
			int i;
			if (count == 0) hdr = b;
			else for (i = 7; i >= 0; i--) golomb_step(b[i]);
			if (count <= NAL_MAX) count++;
		endfunction

		function nal_rec_t unit_result(logic eos);
			nal_rec_t   r;
			logic [7:0] h;
			logic [3:0] k;
			h = (count > 0) ? hdr : 8'h00;
			r = '0;
			r.status = ST_OK;
			r.prefix = pfx;
			r.length = (count > NAL_MAX) ? LEN_W'(NAL_MAX) : LEN_W'(count);
			r.ovf = (count > NAL_MAX);
			r.fz = h[7];
			r.idc = h[6:5];
			r.utype = h[4:0];
			r.done = eos;
			k = (kind >= SL_WRAP) ? kind - SL_WRAP : kind;
			if (r.utype == NUT_SLICE || r.utype == NUT_IDR) begin
				case (k)
					SL_P, SL_SP: r.fclass = FC_P;
					SL_B:        r.fclass = FC_B;
					SL_I, SL_SI: r.fclass = FC_I;
					default:     r.fclass = FC_NONE;
				endcase
			end else if (r.utype == NUT_SEI) r.fclass = FC_SEI;
			else if (r.utype == NUT_SPS) r.fclass = FC_SPS;
			else if (r.utype == NUT_PPS) r.fclass = FC_PPS;
			else r.fclass = FC_NONE;
			return r;
		endfunction

		function void parse_byte(logic [7:0] b, logic eos);
			nal_rec_t r;
			r = '0;
			if (mode == MD_SKIP) begin
				if (eos) clear_stream();
				return;
			end
			window = {window[23:0], b};
			pend++;
			if (mode == MD_HEAD) begin
				if (pend == 3 && window[23:0] == START3) open_unit(PFX3);
				else if (pend >= 4) begin
					if (window == START4) open_unit(PFX4);
					else begin
						r.status = ST_NOSTART;
						r.done = eos;
						expected_nals.push_back(r);
						clear_stream();
						if (!eos) mode = MD_SKIP;
						return;
					end
				end else begin
					if (eos) begin
						r.status = ST_SHORT;
						r.done = 1'b1;
						expected_nals.push_back(r);
						clear_stream();
					end
					return;
				end
				mode = MD_UNIT;
				if (eos) begin
					expected_nals.push_back(unit_result(1'b1));
					clear_stream();
				end
				return;
			end
			if (window == START4) begin
				expected_nals.push_back(unit_result(eos));
				if (eos) clear_stream();
				else open_unit(PFX4);
				return;
			end
			if (window[23:0] == START3) begin
				if (pend >= 4) absorb(window[31:24]);
				expected_nals.push_back(unit_result(eos));
				if (eos) clear_stream();
				else open_unit(PFX3);
				return;
			end
			if (pend >= 4) begin
				absorb(window[31:24]);
				pend = 3;
			end
			if (eos) begin
				while (pend > 0) begin
					absorb(window[(pend - 1) * 8 +: 8]);
					pend--;
				end
				expected_nals.push_back(unit_result(1'b1));
				clear_stream();
			end
		endfunction

		function void cmp_field(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(nal_rec_t got);
			nal_rec_t e;
			if (expected_nals.size() == 0) begin
				$error("result with none pending: status %0d, length %0d", got.status,
					got.length);
				errors++;
				return;
			end
			e = expected_nals.pop_front();
			n_results++;
			if (e.status != ST_OK) n_faults++;
			if (e.ovf) n_saturated++;
			cmp_field("status", e.status, got.status);
			cmp_field("prefix_length", e.prefix, got.prefix);
			cmp_field("nal_length", e.length, got.length);
			cmp_field("length_overflow", e.ovf, got.ovf);
			cmp_field("forbidden_zero", e.fz, got.fz);
			cmp_field("reference_idc", e.idc, got.idc);
			cmp_field("unit_type", e.utype, got.utype);
			cmp_field("frame_class", e.fclass, got.fclass);
			cmp_field("stream_done", e.done, got.done);
		endfunction

		function int pending();
			return expected_nals.size();
		endfunction
	endclass

	bit               clk;
	bit               arst_n;
	bit               in_valid;
	logic             in_stall;
	bit [7:0]         data_byte;
	bit               end_of_stream;
	logic             out_valid;
	bit               out_stall;
	logic [1:0]       status;
	logic [2:0]       prefix_length;
	logic [LEN_W-1:0] nal_length;
	logic             length_overflow;
	logic             forbidden_zero;
	logic [1:0]       reference_idc;
	logic [4:0]       unit_type;
	logic [2:0]       frame_class;
	logic             stream_done;

	nal_scoreboard sb = new();
	bit            quiet;
	int            cycles;
	int            sent;
	int            streams;
	logic [7:0]    stream_q[$];
	logic          bits_q[$];

	annexb_nal_splitter_classifier #(.MAX_NAL_BYTES(NAL_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.prefix_length(prefix_length),
		.nal_length(nal_length),
		.length_overflow(length_overflow),
		.forbidden_zero(forbidden_zero),
		.reference_idc(reference_idc),
		.unit_type(unit_type),
		.frame_class(frame_class),
		.stream_done(stream_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 30);

	always @(posedge clk) begin
		nal_rec_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status_t'(status);
			got.prefix = prefix_length;
			got.length = nal_length;
			got.ovf = length_overflow;
			got.fz = forbidden_zero;
			got.idc = reference_idc;
			got.utype = unit_type;
			got.fclass = frame_class;
			got.done = stream_done;
			sb.check_result(got);
		end
	end

	task automatic send_byte(logic [7:0] b, logic eos);
		if (!quiet)
			while ($urandom_range(0, 99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		sb.parse_byte(b, eos);
	endtask

	task automatic send_stream();
		int i;
		for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
		streams++;
	endtask

	// hold the sender until the block has nothing left to report
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic void add_start(bit four);
		if (four) stream_q.push_back(8'h00);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h01);
	endfunction

	function automatic void put_ue(int unsigned v);
		logic [32:0] w;
		int          m;
		int          i;
		w = 33'(v) + 33'd1;
		m = 0;
		while ((w >> (m + 1)) != 0) m++;
		repeat (m) bits_q.push_back(1'b0);
		for (i = m; i >= 0; i--) bits_q.push_back(w[i]);
	endfunction

	function automatic void add_slice_fields();
		int unsigned mb;
		int unsigned st;
		int          n;
		int          i;
		int          j;
		logic [7:0]  b;
		bits_q.delete();
		mb = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(0, 1 << 20);
		st = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 9) : $urandom_range(10, 40);
		put_ue(mb);
		put_ue(st);
		while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));
		n = bits_q.size() / 8;
		if ($urandom_range(0, 9) == 0) n = 1;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < 8; j++) b[7 - j] = bits_q[i * 8 + j];
			stream_q.push_back(b);
		end
	endfunction

	function automatic void add_unit();
		int         sel;
		int         i;
		logic [7:0] h;
		if ($urandom_range(0, 14) == 0) return;
		sel = $urandom_range(0, 9);
		h = 8'($urandom);
		if (sel < 5) h[4:0] = $urandom_range(0, 1) ? NUT_SLICE : NUT_IDR;
		else if (sel == 5) h[4:0] = NUT_SEI;
		else if (sel == 6) h[4:0] = NUT_SPS;
		else if (sel == 7) h[4:0] = NUT_PPS;
		if ($urandom_range(0, 9) != 0) h[7] = 1'b0;
		stream_q.push_back(h);
		if (h[4:0] == NUT_SLICE || h[4:0] == NUT_IDR) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat (4) stream_q.push_back(8'h00);
				stream_q.push_back(8'hff);
			end else if ($urandom_range(0, 9) != 0) add_slice_fields();
		end
		if ($urandom_range(0, 9) == 0) begin
			stream_q.push_back(8'h00);
			stream_q.push_back(8'h00);
			stream_q.push_back(8'h03);
		end
		for (i = $urandom_range(0, 6); i > 0; i--) stream_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_good_stream();
		int n;
		int i;
		add_start(1'($urandom_range(0, 1)));
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
		for (i = 0; i < n; i++) begin
			if (i > 0) add_start(1'($urandom_range(0, 1)));
			add_unit();
		end
		if (n > 0 && $urandom_range(0, 7) == 0) add_start(1'($urandom_range(0, 1)));
	endfunction

	function automatic void add_noise(int len);
		int sel;
		repeat (len) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) stream_q.push_back(8'h00);
			else if (sel < 7) stream_q.push_back(8'h01);
			else stream_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void add_bad_head();
		if ($urandom_range(0, 1)) begin
			stream_q.push_back(8'($urandom_range(1, 255)));
			repeat (3) stream_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat (3) stream_q.push_back(8'h00);
			stream_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255)));
		end
		repeat ($urandom_range(0, 5)) stream_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		int  sel;
		bit  paused;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		stream_q = '{8'h00, 8'h00};
		send_stream();
		stream_q = '{8'h00, 8'h00, 8'h01};
		send_stream();
		stream_q = '{8'h12, 8'h34, 8'h56, 8'h78, 8'hff};
		send_stream();
		stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88, 8'h00, 8'h00, 8'h01,
			8'he8, 8'h00, 8'h00, 8'h00, 8'h01};
		send_stream();
		drain_results();

		sent = 0;
		paused = 1'b0;
		while (sent < 1020) begin
			quiet = (sent >= 300 && sent < 500);
			if (!paused && sent >= 700) begin
				drain_results();
				paused = 1'b1;
			end
			stream_q.delete();
			sel = $urandom_range(0, 99);
			if (sel < 75) add_good_stream();
			else if (sel < 85) add_noise($urandom_range(1, 12));
			else if (sel < 93) add_bad_head();
			else add_noise($urandom_range(1, 3));
			send_stream();
			sent += stream_q.size();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d streams (%0d bytes in the random phase), %0d results",
			streams, sent, sb.n_results);
		$display("of which %0d stream errors and %0d saturated lengths", sb.n_faults,
			sb.n_saturated);
		if (sb.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
